### hw/rtl/tbo_pkg.sv
package tbo_pkg;

    localparam int COORD_BITS    = 21;
    localparam int AXES          = 3;
    localparam int RANK_BITS     = 10;
    localparam int RANK_MAX      = 1024;
    localparam int COUNT_BITS    = $clog2(RANK_MAX + 1);
    localparam int PROD_BITS     = 2 * COORD_BITS;
    localparam int VOL_BITS      = 3 * COORD_BITS;
    localparam int CFG_IDX_BITS  = 3;

    localparam int IN_FIELD_BITS = 2 * AXES * COORD_BITS + RANK_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * AXES * COORD_BITS + VOL_BITS + RANK_BITS + COUNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   coord_end_t;
    typedef logic [RANK_BITS-1:0]  rank_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PROD_BITS-1:0]  prod_t;
    typedef logic [VOL_BITS-1:0]   vol_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TILE_OFF_X = 3'd0,
        CFG_TILE_OFF_Y = 3'd1,
        CFG_TILE_OFF_Z = 3'd2,
        CFG_TILE_LEN_X = 3'd3,
        CFG_TILE_LEN_Y = 3'd4,
        CFG_TILE_LEN_Z = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2
    } ctrl_state_t;

    typedef struct packed {
        logic load_a;
        logic mul1;
        logic mul2;
        logic upd;
    } dp_cmd_t;

endpackage

### hw/rtl/tbo_ctrl.sv
module tbo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output tbo_pkg::dp_cmd_t cmd
);
    import tbo_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        b_valid_reg;
    logic        b_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        cmd.upd    = b_valid_reg && (!out_valid_reg || out_ready);
        b_free     = !b_valid_reg || cmd.upd;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_a = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (b_free)
                begin
                    cmd.mul2 = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_a = 1'b1;
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        b_valid_next   = cmd.mul2 ? 1'b1 : (cmd.upd ? 1'b0 : b_valid_reg);
        out_valid_next = cmd.upd ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/tbo_dp.sv
module tbo_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tbo_pkg::dp_cmd_t                    cmd,
    input  logic                                cfg_we,
    input  logic [tbo_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tbo_pkg::COORD_BITS-1:0]      cfg_data,
    input  logic [tbo_pkg::IN_DATA_BITS-1:0]    in_data,
    input  logic                                in_last,
    output logic [tbo_pkg::OUT_DATA_BITS-1:0]   out_data,
    output logic                                out_overlap,
    output logic                                out_last
);
    import tbo_pkg::*;

    coord_t [AXES-1:0] tile_off_reg;
    coord_t [AXES-1:0] tile_len_reg;

    coord_t [AXES-1:0] lo_c;
    coord_t [AXES-1:0] ext_c;
    logic              hit_c;

    logic              hit_a_reg;
    coord_t [AXES-1:0] lo_a_reg;
    coord_t [AXES-1:0] ext_a_reg;
    rank_t             rank_a_reg;
    logic              last_a_reg;

    prod_t             prod_reg;
    prod_t             mul_a;
    coord_t            mul_b;
    vol_t              mul_p;

    logic              hit_b_reg;
    coord_t [AXES-1:0] lo_b_reg;
    coord_t [AXES-1:0] ext_b_reg;
    vol_t              vol_b_reg;
    rank_t             rank_b_reg;
    logic              last_b_reg;

    vol_t              best_vol_reg;
    vol_t              best_vol_next;
    rank_t             best_rank_reg;
    rank_t             best_rank_next;
    count_t            count_reg;
    count_t            count_next;
    rank_t             owner_c;
    count_t            count_c;
    logic              win;

    coord_t [AXES-1:0] out_lo_reg;
    coord_t [AXES-1:0] out_ext_reg;
    vol_t              out_vol_reg;
    rank_t             out_owner_reg;
    count_t            out_count_reg;
    logic              out_hit_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_off_reg <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                tile_len_reg[a] <= COORD_BITS'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TILE_OFF_X: tile_off_reg[0] <= cfg_data;
                CFG_TILE_OFF_Y: tile_off_reg[1] <= cfg_data;
                CFG_TILE_OFF_Z: tile_off_reg[2] <= cfg_data;
                CFG_TILE_LEN_X: tile_len_reg[0] <= cfg_data;
                CFG_TILE_LEN_Y: tile_len_reg[1] <= cfg_data;
                CFG_TILE_LEN_Z: tile_len_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // per-axis clip of the incoming box against the tile
    always_comb
    begin
        coord_t     bo;
        coord_t     bl;
        coord_t     s;
        coord_end_t be;
        coord_end_t te;
        coord_end_t e;
        hit_c = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            bo = in_data[a*COORD_BITS +: COORD_BITS];
            bl = in_data[(AXES+a)*COORD_BITS +: COORD_BITS];
            be = {1'b0, bo} + {1'b0, bl};
            te = {1'b0, tile_off_reg[a]} + {1'b0, tile_len_reg[a]};
            s  = (bo > tile_off_reg[a]) ? bo : tile_off_reg[a];
            e  = (be < te) ? be : te;
            lo_c[a]  = s;
            ext_c[a] = COORD_BITS'(e - {1'b0, s});
            if (!({1'b0, s} < e))
            begin
                hit_c = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            hit_a_reg  <= hit_c;
            lo_a_reg   <= hit_c ? lo_c : '0;
            ext_a_reg  <= hit_c ? ext_c : '0;
            rank_a_reg <= in_data[2*AXES*COORD_BITS +: RANK_BITS];
            last_a_reg <= in_last;
        end
    end

    // one multiplier, used for x*y and then for (x*y)*z
    assign mul_a = cmd.mul2 ? prod_reg : PROD_BITS'(ext_a_reg[0]);
    assign mul_b = cmd.mul2 ? ext_a_reg[2] : ext_a_reg[1];
    assign mul_p = VOL_BITS'(mul_a) * VOL_BITS'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            prod_reg <= mul_p[PROD_BITS-1:0];
        end
        if (cmd.mul2)
        begin
            hit_b_reg  <= hit_a_reg;
            lo_b_reg   <= lo_a_reg;
            ext_b_reg  <= ext_a_reg;
            vol_b_reg  <= mul_p;
            rank_b_reg <= rank_a_reg;
            last_b_reg <= last_a_reg;
        end
    end

    always_comb
    begin
        win     = hit_b_reg && ((count_reg == '0) || (vol_b_reg > best_vol_reg));
        owner_c = win ? rank_b_reg : best_rank_reg;
        count_c = (hit_b_reg && (count_reg < COUNT_BITS'(RANK_MAX))) ?
                  count_reg + COUNT_BITS'(1) : count_reg;
        best_vol_next  = best_vol_reg;
        best_rank_next = best_rank_reg;
        count_next     = count_reg;
        if (cmd.upd)
        begin
            if (last_b_reg)
            begin
                best_vol_next  = '0;
                best_rank_next = '0;
                count_next     = '0;
            end
            else
            begin
                best_vol_next  = win ? vol_b_reg : best_vol_reg;
                best_rank_next = owner_c;
                count_next     = count_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_vol_reg  <= '0;
            best_rank_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            best_vol_reg  <= best_vol_next;
            best_rank_reg <= best_rank_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            out_lo_reg    <= lo_b_reg;
            out_ext_reg   <= ext_b_reg;
            out_vol_reg   <= vol_b_reg;
            out_owner_reg <= owner_c;
            out_count_reg <= count_c;
            out_hit_reg   <= hit_b_reg;
            out_last_reg  <= last_b_reg;
        end
    end

    assign out_data = OUT_DATA_BITS'({out_count_reg, out_owner_reg, out_vol_reg,
                                      out_ext_reg, out_lo_reg});
    assign out_overlap = out_hit_reg;
    assign out_last    = out_last_reg;

endmodule

### hw/rtl/tile_box_overlap_owner_select_core.sv
// channel  dir  handshake                  payload
// s_*      in   s_tvalid / s_tready        s_tdata (boxes), s_tlast (last box)
// m_*      out  m_tvalid / m_tready        m_tdata (clip, owner), m_tuser, m_tlast
// cfg_*    in   cfg_valid / cfg_ready      cfg_index, cfg_data (tile registers)
//
// The single 42x21 multiplier forms x*y, then (x*y)*z; a new box is taken only when idle
// or as the previous box does (x*y)*z. A box passes the clip, product and volume
// registers before the result register; owner update runs in parallel with the next
// box. Reset clears the tile to offset 0, length 1 and the owner state. A stalled m
// side holds one result, one finished volume and one box in the multiplier, then
// stops s_tready. cfg_ready is always high.
module tile_box_overlap_owner_select_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // box_off_x, box_off_y, box_off_z, box_len_x, box_len_y, box_len_z, rank_id
    input  logic [tbo_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // clip_off_x, clip_off_y, clip_off_z, clip_len_x, clip_len_y, clip_len_z,
    // clip_volume, owner_rank, contributor_count, zero pad
    output logic [tbo_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // overlaps
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tbo_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tbo_pkg::COORD_BITS-1:0]     cfg_data
);
    import tbo_pkg::*;

    localparam int VOL_LSB   = 2 * AXES * COORD_BITS;
    localparam int COUNT_LSB = VOL_LSB + VOL_BITS + RANK_BITS;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tbo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    tbo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .out_data    (m_tdata),
        .out_overlap (m_tuser),
        .out_last    (m_tlast)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[COUNT_LSB +: COUNT_BITS] <= COUNT_BITS'(RANK_MAX)))
        else $error("contributor count above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[VOL_LSB +: VOL_BITS] == '0))
        else $error("nonzero volume without overlap");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[COUNT_LSB +: COUNT_BITS] != '0))
        else $error("overlap with zero contributor count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("box taken in back-to-back cycles");

endmodule
